// File: hdl/wps_pkg.sv
// shared constants, codes and control types of the waypoint path stepper
package wps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 24;
  localparam int STEP_BITS  = 23;
  localparam int DIST_BITS  = 32;

  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int ROOT_W    = DIFF_W;
  localparam int NUM_W     = DIFF_W + STEP_BITS + 1;
  localparam int SUM_W     = ((ROOT_W > DIST_BITS) ? ROOT_W : DIST_BITS) + 1;
  localparam int CFG_W     = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS;
  localparam int REG_IDX_W = 2;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_STEP_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_X     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_Y     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_Z     = 2'd3;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(2560);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic       ram_we;
    logic       rd_scan;
    logic       set_status;
    logic [1:0] status;
    logic       clear;
    logic       load_rem;
    logic       a_from_here;
    logic       a_from_b;
    logic       b_from_ram;
    logic       dist_start;
    logic       take_b;
    logic       inc_target;
    logic       adv_start;
    logic       sum_init;
    logic       sum_add;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic dist_done;
    logic adv_done;
    logic d_le_rem;
    logic last_target;
    logic seg_last;
  } sts_t;

endpackage

// File: hdl/wps_in_if.sv
// command channel: function code and waypoint coordinates
interface wps_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  wps_pkg::coord_t  point_x;
  wps_pkg::coord_t  point_y;
  wps_pkg::coord_t  point_z;

  modport source (output valid, func, point_x, point_y, point_z, input ready);
  modport sink   (input valid, func, point_x, point_y, point_z, output ready);
endinterface

// File: hdl/wps_out_if.sv
// result channel: position, distances, target and status
interface wps_out_if;
  logic                        valid;
  logic                        ready;
  wps_pkg::coord_t             pos_x;
  wps_pkg::coord_t             pos_y;
  wps_pkg::coord_t             pos_z;
  logic [wps_pkg::DIST_BITS-1:0] to_waypoint;
  logic [wps_pkg::DIST_BITS-1:0] to_end;
  logic [wps_pkg::IDX_W-1:0]   target_index;
  logic                        arrived;
  logic [1:0]                  status;

  modport source (output valid, pos_x, pos_y, pos_z, to_waypoint, to_end, target_index,
                  arrived, status, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, to_waypoint, to_end, target_index,
                  arrived, status, output ready);
endinterface

// File: hdl/wps_ram.sv
// generic single write port ram with registered read
module wps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hdl/wps_ctrl.sv
// sequencer of the waypoint path stepper
module wps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    func_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  wps_pkg::sts_t sts_i,
  output wps_pkg::cmd_t cmd_o
);
  import wps_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_STEP_RD   = 13'h0002,
    S_STEP_LD   = 13'h0004,
    S_STEP_DIST = 13'h0008,
    S_ADV       = 13'h0010,
    S_REP_RD    = 13'h0020,
    S_REP_LD    = 13'h0040,
    S_REP_DIST  = 13'h0080,
    S_SEG_RD    = 13'h0100,
    S_SEG_LD    = 13'h0200,
    S_SEG_DIST  = 13'h0400,
    S_OUT       = 13'h0800,
    S_SPARE     = 13'h1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.set_status = 1'b1;
          cmd.status     = STATUS_OK;
          state_d        = S_REP_RD;
          case (func_i)
            FUNC_APPEND: begin
              if (sts_i.count_full) begin
                cmd.status = STATUS_FULL;
              end else begin
                cmd.ram_we = 1'b1;
              end
            end
            FUNC_STEP: begin
              if (sts_i.count_zero) begin
                cmd.status = STATUS_EMPTY;
              end else begin
                cmd.load_rem = 1'b1;
                state_d      = S_STEP_RD;
              end
            end
            FUNC_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_STEP_RD: begin
        cmd.a_from_here = 1'b1;
        state_d         = S_STEP_LD;
      end
      S_STEP_LD: begin
        cmd.b_from_ram = 1'b1;
        cmd.dist_start = 1'b1;
        state_d        = S_STEP_DIST;
      end
      S_STEP_DIST: begin
        if (sts_i.dist_done) begin
          if (sts_i.d_le_rem) begin
            cmd.take_b = 1'b1;
            if (sts_i.last_target) begin
              state_d = S_REP_RD;
            end else begin
              cmd.inc_target = 1'b1;
              state_d        = S_STEP_RD;
            end
          end else begin
            cmd.adv_start = 1'b1;
            state_d       = S_ADV;
          end
        end
      end
      S_ADV: begin
        if (sts_i.adv_done) begin
          state_d = S_REP_RD;
        end
      end
      S_REP_RD: begin
        if (sts_i.count_zero) begin
          state_d = S_OUT;
        end else begin
          cmd.a_from_here = 1'b1;
          state_d         = S_REP_LD;
        end
      end
      S_REP_LD: begin
        cmd.b_from_ram = 1'b1;
        cmd.dist_start = 1'b1;
        state_d        = S_REP_DIST;
      end
      S_REP_DIST: begin
        if (sts_i.dist_done) begin
          cmd.sum_init = 1'b1;
          state_d      = sts_i.last_target ? S_OUT : S_SEG_RD;
        end
      end
      S_SEG_RD: begin
        cmd.rd_scan  = 1'b1;
        cmd.a_from_b = 1'b1;
        state_d      = S_SEG_LD;
      end
      S_SEG_LD: begin
        cmd.b_from_ram = 1'b1;
        cmd.dist_start = 1'b1;
        state_d        = S_SEG_DIST;
      end
      S_SEG_DIST: begin
        if (sts_i.dist_done) begin
          cmd.sum_add = 1'b1;
          state_d     = sts_i.seg_last ? S_OUT : S_SEG_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register empties when the beat is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;
endmodule

// File: hdl/wps_dpath.sv
// datapath: waypoint store, position, distance and advance units
module wps_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wps_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wps_pkg::CFG_W-1:0]           cfg_data_i,
  input  wps_pkg::coord_t                     point_x_i,
  input  wps_pkg::coord_t                     point_y_i,
  input  wps_pkg::coord_t                     point_z_i,
  input  wps_pkg::cmd_t                       cmd_i,
  output wps_pkg::sts_t                       sts_o,
  output wps_pkg::coord_t                     pos_x_o,
  output wps_pkg::coord_t                     pos_y_o,
  output wps_pkg::coord_t                     pos_z_o,
  output logic [wps_pkg::DIST_BITS-1:0]       to_waypoint_o,
  output logic [wps_pkg::DIST_BITS-1:0]       to_end_o,
  output logic [wps_pkg::IDX_W-1:0]           target_index_o,
  output logic                                arrived_o,
  output logic [1:0]                          status_o
);
  import wps_pkg::*;

  localparam int PH_W  = $clog2(ROOT_W + 5);
  localparam int APH_W = $clog2(NUM_W + 3);
  localparam logic [SUM_W-1:0] DMAX = SUM_W'(33'h0_FFFF_FFFF);

  logic [STEP_BITS-1:0] step_len_q;
  coord_t               start_q [3];
  coord_t               here_q  [3];
  coord_t               pa_q    [3];
  coord_t               pb_q    [3];
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     target_q, scan_q;
  logic [STEP_BITS-1:0] rem_q;
  logic [1:0]           status_q;

  // ram holds {z, y, x}
  logic [3*COORD_BITS-1:0] rdata;
  logic [IDX_W-1:0]        raddr;
  logic                    we;

  assign we    = cmd_i.ram_we;
  assign raddr = cmd_i.rd_scan ? IDX_W'(scan_q + 1'b1) : target_q;

  wps_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({point_z_i, point_y_i, point_x_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // distance unit: three squares on one multiplier, then a root digit a cycle
  logic              dbusy_q, ddone_q;
  logic [PH_W-1:0]   dph_q;
  logic [SQ_W-1:0]   sq_q, acc_q;
  logic [ROOT_W-1:0] root_q, d_q, root_n;
  logic [ROOT_W+1:0] rr_q, rr_n;
  logic [1:0]        daxis;
  logic signed [DIFF_W-1:0] ddiff;
  logic [DIFF_W-1:0] dmag;
  logic [SQ_W-1:0]   sq;
  logic [ROOT_W+3:0] rext, rtrial;
  logic              rge;

  always_comb begin
    daxis  = (dph_q < PH_W'(3)) ? dph_q[1:0] : 2'd0;
    ddiff  = DIFF_W'(pb_q[daxis]) - DIFF_W'(pa_q[daxis]);
    dmag   = ddiff[DIFF_W-1] ? $unsigned(-ddiff) : $unsigned(ddiff);
    sq     = dmag * dmag;
    rext   = {rr_q, acc_q[SQ_W-1 -: 2]};
    rtrial = (ROOT_W + 4)'({root_q, 2'b01});
    rge    = (rext >= rtrial);
    rr_n   = rge ? (ROOT_W + 2)'(rext - rtrial) : (ROOT_W + 2)'(rext);
    root_n = {root_q[ROOT_W-2:0], rge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dph_q   <= '0;
      sq_q    <= '0;
      acc_q   <= '0;
      rr_q    <= '0;
      root_q  <= '0;
      d_q     <= '0;
    end else if (cmd_i.dist_start) begin
      dbusy_q <= 1'b1;
      ddone_q <= 1'b0;
      dph_q   <= '0;
      acc_q   <= '0;
      rr_q    <= '0;
      root_q  <= '0;
    end else if (dbusy_q) begin
      dph_q <= dph_q + 1'b1;
      if (dph_q < PH_W'(3)) begin
        sq_q <= sq;
      end
      if (dph_q >= PH_W'(1) && dph_q <= PH_W'(3)) begin
        acc_q <= acc_q + sq_q;
      end
      if (dph_q >= PH_W'(4)) begin
        acc_q  <= acc_q << 2;
        rr_q   <= rr_n;
        root_q <= root_n;
      end
      if (dph_q == PH_W'(3 + ROOT_W)) begin
        dbusy_q <= 1'b0;
        ddone_q <= 1'b1;
        d_q     <= root_n;
      end
    end
  end

  // advance unit: per axis round(|delta| * rem / d) by restoring division
  logic                 abusy_q, adone_q, aneg_q;
  logic [APH_W-1:0]     aph_q;
  logic [1:0]           axis_q;
  logic [NUM_W-2:0]     prod_q;
  logic [NUM_W-1:0]     num_q, quo_q, quo_n;
  logic [ROOT_W:0]      dr_q, dr_n;
  logic [ROOT_W+1:0]    dext;
  logic                 dge;
  logic signed [DIFF_W-1:0] adiff;
  logic [DIFF_W-1:0]    amag;
  coord_t               afrom, anew;

  always_comb begin
    afrom = here_q[axis_q];
    adiff = DIFF_W'(pb_q[axis_q]) - DIFF_W'(afrom);
    amag  = adiff[DIFF_W-1] ? $unsigned(-adiff) : $unsigned(adiff);
    dext  = {dr_q, num_q[NUM_W-1]};
    dge   = (dext >= (ROOT_W + 2)'(d_q));
    dr_n  = dge ? (ROOT_W + 1)'(dext - (ROOT_W + 2)'(d_q)) : (ROOT_W + 1)'(dext);
    quo_n = {quo_q[NUM_W-2:0], dge};
    anew  = aneg_q ? afrom - $signed(quo_n[COORD_BITS-1:0])
                   : afrom + $signed(quo_n[COORD_BITS-1:0]);
  end

  logic [CNT_W:0] tgt_p1, scan_p2;
  assign tgt_p1  = (CNT_W + 1)'(target_q) + 1'b1;
  assign scan_p2 = (CNT_W + 1)'(scan_q) + 2'd2;

  // state, configuration and the advance sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q <= STEP_RESET;
      for (int k = 0; k < 3; k++) begin
        start_q[k] <= '0;
        here_q[k]  <= '0;
      end
      count_q  <= '0;
      target_q <= '0;
      scan_q   <= '0;
      rem_q    <= '0;
      status_q <= STATUS_OK;
      abusy_q  <= 1'b0;
      adone_q  <= 1'b0;
      aneg_q   <= 1'b0;
      aph_q    <= '0;
      axis_q   <= '0;
      prod_q   <= '0;
      num_q    <= '0;
      quo_q    <= '0;
      dr_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_LENGTH: step_len_q <= cfg_data_i[STEP_BITS-1:0];
          REG_START_X:     start_q[0] <= cfg_data_i[COORD_BITS-1:0];
          REG_START_Y:     start_q[1] <= cfg_data_i[COORD_BITS-1:0];
          REG_START_Z:     start_q[2] <= cfg_data_i[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.set_status) status_q <= cmd_i.status;
      if (cmd_i.ram_we)     count_q  <= count_q + 1'b1;
      if (cmd_i.clear) begin
        count_q  <= '0;
        target_q <= '0;
        for (int k = 0; k < 3; k++) here_q[k] <= start_q[k];
      end
      if (cmd_i.load_rem) rem_q <= step_len_q;
      if (cmd_i.take_b) begin
        for (int k = 0; k < 3; k++) here_q[k] <= pb_q[k];
        rem_q <= rem_q - STEP_BITS'(d_q);
      end
      if (cmd_i.inc_target) target_q <= target_q + 1'b1;
      if (cmd_i.sum_init)   scan_q   <= target_q;
      if (cmd_i.sum_add)    scan_q   <= scan_q + 1'b1;

      if (cmd_i.adv_start) begin
        abusy_q <= 1'b1;
        adone_q <= 1'b0;
        aph_q   <= '0;
        axis_q  <= '0;
      end else if (abusy_q) begin
        aph_q <= aph_q + 1'b1;
        if (aph_q == APH_W'(0)) begin
          prod_q <= amag * rem_q;
          aneg_q <= adiff[DIFF_W-1];
        end else if (aph_q == APH_W'(1)) begin
          num_q <= NUM_W'(prod_q) + NUM_W'(d_q >> 1);
          dr_q  <= '0;
          quo_q <= '0;
        end else begin
          num_q <= num_q << 1;
          dr_q  <= dr_n;
          quo_q <= quo_n;
          if (aph_q == APH_W'(NUM_W + 1)) begin
            here_q[axis_q] <= anew;
            aph_q          <= '0;
            if (axis_q == 2'd2) begin
              abusy_q <= 1'b0;
              adone_q <= 1'b1;
            end else begin
              axis_q <= axis_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // operands, path sums and the result register
  logic [DIST_BITS-1:0] sum_q, to_wp_q;
  logic [SUM_W-1:0]     sum_ext, d_ext;
  logic                 count_zero;

  assign d_ext      = SUM_W'(d_q);
  assign sum_ext    = SUM_W'(sum_q) + d_ext;
  assign count_zero = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_from_here) begin
      for (int k = 0; k < 3; k++) pa_q[k] <= here_q[k];
    end
    if (cmd_i.a_from_b) begin
      for (int k = 0; k < 3; k++) pa_q[k] <= pb_q[k];
    end
    if (cmd_i.b_from_ram) begin
      for (int k = 0; k < 3; k++) pb_q[k] <= rdata[k*COORD_BITS +: COORD_BITS];
    end
    if (cmd_i.sum_init) begin
      to_wp_q <= (d_ext > DMAX) ? DMAX[DIST_BITS-1:0] : d_ext[DIST_BITS-1:0];
      sum_q   <= (d_ext > DMAX) ? DMAX[DIST_BITS-1:0] : d_ext[DIST_BITS-1:0];
    end
    if (cmd_i.sum_add) begin
      sum_q <= (sum_ext > DMAX) ? DMAX[DIST_BITS-1:0] : sum_ext[DIST_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      pos_x_o        <= here_q[0];
      pos_y_o        <= here_q[1];
      pos_z_o        <= here_q[2];
      to_waypoint_o  <= count_zero ? '0 : to_wp_q;
      to_end_o       <= count_zero ? '0 : sum_q;
      target_index_o <= target_q;
      arrived_o      <= !count_zero && (tgt_p1 == (CNT_W + 1)'(count_q)) && (to_wp_q == '0);
      status_o       <= status_q;
    end
  end

  always_comb begin
    sts_o.count_zero  = count_zero;
    sts_o.count_full  = (count_q == CNT_W'(MAX_POINTS));
    sts_o.dist_done   = ddone_q && !dbusy_q;
    sts_o.adv_done    = adone_q && !abusy_q;
    sts_o.d_le_rem    = (d_ext <= SUM_W'(rem_q));
    sts_o.last_target = (tgt_p1 >= (CNT_W + 1)'(count_q));
    sts_o.seg_last    = (scan_p2 >= (CNT_W + 1)'(count_q));
  end
endmodule

// File: hdl/waypoint_path_stepper.sv
// top level of the waypoint path stepper
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    func, point_x, point_y, point_z
//  out_o    out  valid/ready    pos_x/y/z, to_waypoint, to_end, target_index, arrived, status
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i (no read-back)
//
// one command at a time; each distance is measured in the shared
// square-and-root unit, so a report measures n - t distances for n
// waypoints and target t; a step adds a measurement for each distance it measures
// and the three per-axis divisions of a partial move
// reset clears position, count and target; the waypoint ram is not cleared
// a stalled result waits in the output register while the next command is taken
module waypoint_path_stepper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wps_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [wps_pkg::CFG_W-1:0]     cfg_data_i,
  wps_in_if.sink                        in_i,
  wps_out_if.source                     out_o
);
  import wps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks step, report and segment loops
  wps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .func_i      (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: waypoint ram, position, distance and advance units
  wps_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .point_x_i      (in_i.point_x),
    .point_y_i      (in_i.point_y),
    .point_z_i      (in_i.point_z),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pos_x_o        (out_o.pos_x),
    .pos_y_o        (out_o.pos_y),
    .pos_z_o        (out_o.pos_z),
    .to_waypoint_o  (out_o.to_waypoint),
    .to_end_o       (out_o.to_end),
    .target_index_o (out_o.target_index),
    .arrived_o      (out_o.arrived),
    .status_o       (out_o.status)
  );
endmodule

// File: hdl/wps_checker.sv
// port-level checks of the waypoint path stepper and their bind
module wps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] to_waypoint_i,
  input logic [31:0] to_end_i,
  input logic        arrived_i,
  input logic [1:0]  status_i
);
  import wps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new command taken while one is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == STATUS_OK || status_i == STATUS_EMPTY ||
                     status_i == STATUS_FULL))
    else $error("bad status code");

  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && arrived_i |-> to_waypoint_i == '0)
    else $error("arrived with distance left");

  a_end_covers_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> to_waypoint_i <= to_end_i)
    else $error("path remainder shorter than target distance");
endmodule

bind waypoint_path_stepper wps_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .to_waypoint_i (out_o.to_waypoint),
  .to_end_i      (out_o.to_end),
  .arrived_i     (out_o.arrived),
  .status_i      (out_o.status)
);

// File: bench/testbench.sv
// testbench of the waypoint path stepper: directed table, random routes, scoreboard
`timescale 1ns / 100ps

module testbench;
  import wps_pkg::*;

  localparam int IDLE_LIMIT = 60000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off

  typedef struct packed {
    coord_t                px;
    coord_t                py;
    coord_t                pz;
    logic [DIST_BITS-1:0]  to_wp;
    logic [DIST_BITS-1:0]  to_end;
    logic [IDX_W-1:0]      tgt;
    logic                  arrived;
    logic [1:0]            status;
  } report_t;

  typedef struct {
    logic [1:0] func;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    bit         known;
    report_t    rep;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  wps_in_if  cmd_ch ();
  wps_out_if rep_ch ();

  waypoint_path_stepper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_ch.sink),
    .out_o      (rep_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block state
  longint     wp_x [MAX_POINTS];
  longint     wp_y [MAX_POINTS];
  longint     wp_z [MAX_POINTS];
  int         wp_count;
  int         wp_target;
  longint     at_x, at_y, at_z;
  longint     stride;
  longint     home_x, home_y, home_z;

  report_t    pending_reports[$];
  int         fail_count = 0;
  int         beats_sent = 0;
  int         in_idle_pct = 0;
  int         out_idle_pct = 0;
  bit         hold_req = 1'b0;

  // sideband for the beat being offered: typed-in expectation
  bit         cur_known = 1'b0;
  report_t    cur_rep;

  // floor of euclidean distance, exact on the integer differences
  function automatic longint unsigned seg_len(longint ax, longint ay, longint az,
                                              longint bx, longint by, longint bz);
    longint unsigned sq, root, trial;
    sq = longint'((bx - ax) * (bx - ax)) + longint'((by - ay) * (by - ay))
       + longint'((bz - az) * (bz - az));
    root = 0;
    for (int b = 27; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned gap_to_target();
    return seg_len(at_x, at_y, at_z, wp_x[wp_target], wp_y[wp_target], wp_z[wp_target]);
  endfunction

  // partial move on one axis, magnitude rounded half away from zero
  function automatic longint move_axis(longint from, longint to, longint unsigned budget,
                                       longint unsigned d);
    longint delta;
    longint unsigned mag_d, q;
    delta = to - from;
    mag_d = (delta < 0) ? longint'(-delta) : longint'(delta);
    q = (mag_d * budget + d / 2) / d;
    return (delta < 0) ? from - longint'(q) : from + longint'(q);
  endfunction

  function automatic void walk_path();
    longint unsigned budget, d;
    budget = stride;
    forever begin
      d = gap_to_target();
      if (d <= budget) begin
        at_x = wp_x[wp_target];
        at_y = wp_y[wp_target];
        at_z = wp_z[wp_target];
        budget -= d;
        if (wp_target + 1 >= wp_count) return;
        wp_target++;
      end else begin
        at_x = move_axis(at_x, wp_x[wp_target], budget, d);
        at_y = move_axis(at_y, wp_y[wp_target], budget, d);
        at_z = move_axis(at_z, wp_z[wp_target], budget, d);
        return;
      end
    end
  endfunction

  // applies one command to the mirror and returns the report it yields
  function automatic report_t follow_cmd(logic [1:0] func, coord_t x, coord_t y, coord_t z);
    report_t r;
    longint unsigned d, total;
    r = '0;
    if (func == FUNC_APPEND) begin
      if (wp_count < MAX_POINTS) begin
        wp_x[wp_count] = x;
        wp_y[wp_count] = y;
        wp_z[wp_count] = z;
        wp_count++;
      end else r.status = STATUS_FULL;
    end else if (func == FUNC_STEP) begin
      if (wp_count == 0) r.status = STATUS_EMPTY;
      else walk_path();
    end else if (func == FUNC_CLEAR) begin
      wp_count = 0;
      wp_target = 0;
      at_x = home_x;
      at_y = home_y;
      at_z = home_z;
    end
    if (wp_count > 0 && wp_target < wp_count) begin
      d = gap_to_target();
      total = d;
      for (int i = wp_target; i + 1 < wp_count; i++) begin
        total += seg_len(wp_x[i], wp_y[i], wp_z[i], wp_x[i+1], wp_y[i+1], wp_z[i+1]);
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      end
      r.to_wp = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
      r.to_end = total[31:0];
      r.arrived = (wp_target + 1 == wp_count) && (d == 0);
    end
    r.px = coord_t'(at_x);
    r.py = coord_t'(at_y);
    r.pz = coord_t'(at_z);
    r.tgt = wp_target[IDX_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // command side: predict on every accepted beat
  // result side: compare against the oldest pending report
  // also the watchdog on cycles with no beat at all
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    report_t r;
    bit moved;
    moved = 1'b0;
    if (rst_ni && cmd_ch.valid && cmd_ch.ready) begin
      r = follow_cmd(cmd_ch.func, cmd_ch.point_x, cmd_ch.point_y, cmd_ch.point_z);
      pending_reports.insert(pending_reports.size(), cur_known ? cur_rep : r);
      moved = 1'b1;
    end
    if (rst_ni && rep_ch.valid && rep_ch.ready) begin
      moved = 1'b1;
      if (pending_reports.size() == 0) begin
        $error("result beat with no command pending");
        fail_count++;
      end else begin
        r = pending_reports.pop_front();
        check_field("pos_x", longint'(r.px) & 24'hFFFFFF, longint'(rep_ch.pos_x) & 24'hFFFFFF);
        check_field("pos_y", longint'(r.py) & 24'hFFFFFF, longint'(rep_ch.pos_y) & 24'hFFFFFF);
        check_field("pos_z", longint'(r.pz) & 24'hFFFFFF, longint'(rep_ch.pos_z) & 24'hFFFFFF);
        check_field("to_waypoint", r.to_wp, rep_ch.to_waypoint);
        check_field("to_end", r.to_end, rep_ch.to_end);
        check_field("target_index", r.tgt, rep_ch.target_index);
        check_field("arrived", r.arrived, rep_ch.arrived);
        check_field("status", r.status, rep_ch.status);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random back-pressure, or one long hold-off on request
  initial begin
    rep_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rep_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        rep_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // offers one beat; called at a falling edge, returns at the falling edge after acceptance
  task automatic send_cmd(logic [1:0] func, coord_t x, coord_t y, coord_t z,
                          bit known = 1'b0, report_t rep = '0);
    while ($urandom_range(99) < in_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= func;
    cmd_ch.point_x <= x;
    cmd_ch.point_y <= y;
    cmd_ch.point_z <= z;
    cur_known = known;
    cur_rep = rep;
    do @(posedge clk_i); while (!cmd_ch.ready);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // register write only once every pending report has come back
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, longint value);
    cmd_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_STEP_LENGTH) stride = value & 64'h7FFFFF;
    else if (idx == REG_START_X) home_x = coord_t'(value);
    else if (idx == REG_START_Y) home_y = coord_t'(value);
    else home_z = coord_t'(value);
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near(coord_t c, int span);
    return coord_t'(longint'(c) + $urandom_range(2 * span) - span);
  endfunction

  // clear, load a polyline, then walk it with some noise mixed in
  task automatic run_route(int n, bit wide, int span);
    coord_t x, y, z;
    int steps;
    send_cmd(FUNC_CLEAR, any_coord(), any_coord(), any_coord());
    x = near(coord_t'(home_x), span);
    y = near(coord_t'(home_y), span);
    z = near(coord_t'(home_z), span);
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        x = any_coord(); y = any_coord(); z = any_coord();
      end else begin
        x = near(x, span); y = near(y, span); z = near(z, span);
      end
      send_cmd(FUNC_APPEND, x, y, z);
      if ($urandom_range(9) == 0) send_cmd(FUNC_UNUSED, any_coord(), any_coord(), any_coord());
    end
    steps = $urandom_range(2, 8);
    for (int s = 0; s < steps; s++) begin
      send_cmd(FUNC_STEP, any_coord(), any_coord(), any_coord());
      if ($urandom_range(7) == 0) send_cmd(FUNC_APPEND, near(x, span), near(y, span), near(z, span));
    end
  endtask

  function automatic row_t mk_row(logic [1:0] func, coord_t x, coord_t y, coord_t z,
                                  bit known = 1'b0, report_t rep = '0);
    row_t r;
    r.func = func; r.x = x; r.y = y; r.z = z; r.known = known; r.rep = rep;
    return r;
  endfunction

  function automatic report_t mk_rep(longint wpd, longint endd, bit arr, logic [1:0] st);
    report_t r;
    r = '0;
    r.to_wp = wpd[31:0];
    r.to_end = endd[31:0];
    r.arrived = arr;
    r.status = st;
    return r;
  endfunction

  row_t directed[$];

  function automatic void add_row(row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    coord_t cmax, cmin;
    cmax = coord_t'(24'h7FFFFF);
    cmin = coord_t'(24'h800000);
    cmd_ch.valid = 1'b0;
    cmd_ch.func = FUNC_APPEND;
    cmd_ch.point_x = '0;
    cmd_ch.point_y = '0;
    cmd_ch.point_z = '0;
    wp_count = 0; wp_target = 0;
    at_x = 0; at_y = 0; at_z = 0;
    stride = STEP_RESET;
    home_x = 0; home_y = 0; home_z = 0;

    // state after reset, extremes, special cases
    add_row(mk_row(FUNC_STEP, 0, 0, 0, 1, mk_rep(0, 0, 0, STATUS_EMPTY)));
    add_row(mk_row(FUNC_UNUSED, cmax, cmin, cmax, 1, mk_rep(0, 0, 0, STATUS_OK)));
    add_row(mk_row(FUNC_APPEND, cmax, 0, 0, 1,
                   mk_rep(24'h7FFFFF, 24'h7FFFFF, 0, STATUS_OK)));
    add_row(mk_row(FUNC_APPEND, cmin, cmin, cmin));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_CLEAR, cmax, cmax, cmax, 1, mk_rep(0, 0, 0, STATUS_OK)));
    // waypoint on top of the position: arrived at once
    add_row(mk_row(FUNC_APPEND, 0, 0, 0, 1, mk_rep(0, 0, 1, STATUS_OK)));
    // step after arrival does not move
    add_row(mk_row(FUNC_STEP, 0, 0, 0, 1, mk_rep(0, 0, 1, STATUS_OK)));
    // append after arrival resumes motion; exactly one step length away
    add_row(mk_row(FUNC_APPEND, 2560, 0, 0));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_APPEND, 2560, 1000, -700));
    add_row(mk_row(FUNC_APPEND, 3000, 1200, -900));
    add_row(mk_row(FUNC_APPEND, -5000, 4000, 100));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));
    add_row(mk_row(FUNC_CLEAR, 0, 0, 0));
    add_row(mk_row(FUNC_APPEND, -3, 7, 1));
    add_row(mk_row(FUNC_APPEND, 2, -5, 9));
    add_row(mk_row(FUNC_STEP, 0, 0, 0));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sender busy, receiver slow
    in_idle_pct = 36; out_idle_pct = 64;
    foreach (directed[i])
      send_cmd(directed[i].func, directed[i].x, directed[i].y, directed[i].z,
               directed[i].known, directed[i].rep);

    // zero step length: only coincident waypoints are consumed
    write_reg(REG_STEP_LENGTH, 0);
    send_cmd(FUNC_CLEAR, 0, 0, 0);
    send_cmd(FUNC_APPEND, 0, 0, 0);
    send_cmd(FUNC_APPEND, 0, 0, 0);
    send_cmd(FUNC_APPEND, 300, 0, 0);
    send_cmd(FUNC_STEP, 0, 0, 0);
    send_cmd(FUNC_STEP, 0, 0, 0);

    write_reg(REG_STEP_LENGTH, $urandom_range(200, 5000));
    write_reg(REG_START_X, $urandom_range(200000) - 100000);
    write_reg(REG_START_Y, $urandom_range(200000) - 100000);
    write_reg(REG_START_Z, $urandom_range(200000) - 100000);
    hold_req = 1'b1;  // long stall while the sender keeps offering
    while (beats_sent < 110) run_route($urandom_range(1, 6), 1'b0, 6000);

    // the other way round; extreme registers, wide coordinates, full store
    in_idle_pct = 64; out_idle_pct = 36;
    write_reg(REG_STEP_LENGTH, 24'h7FFFFF);
    write_reg(REG_START_X, 24'h7FFFFF);
    write_reg(REG_START_Y, 24'h800000);
    write_reg(REG_START_Z, 24'h7FFFFF);
    run_route(3, 1'b1, 0);
    run_route(4, 1'b1, 0);
    write_reg(REG_STEP_LENGTH, $urandom_range(1000, 40000));
    write_reg(REG_START_X, 24'h800000);
    write_reg(REG_START_Y, 24'h7FFFFF);
    write_reg(REG_START_Z, 24'h800000);
    send_cmd(FUNC_CLEAR, 0, 0, 0);
    for (int i = 0; i < MAX_POINTS + 2; i++)
      send_cmd(FUNC_APPEND, near(coord_t'(-8380000), 3000), near(coord_t'(8380000), 3000),
               near(coord_t'(-8380000), 3000));
    send_cmd(FUNC_STEP, 0, 0, 0);
    send_cmd(FUNC_STEP, 0, 0, 0);

    // no idling on either side
    in_idle_pct = 0; out_idle_pct = 0;
    while (beats_sent < 290) begin
      write_reg(REG_STEP_LENGTH, $urandom_range(9) == 0 ? $urandom & 24'h7FFFFF
                                                        : $urandom_range(100, 8000));
      write_reg(REG_START_X, any_coord());
      write_reg(REG_START_Y, any_coord());
      write_reg(REG_START_Z, any_coord());
      for (int k = 0; k < 3 && beats_sent < 290; k++)
        run_route($urandom_range(1, 8), $urandom_range(3) == 0, 9000);
    end

    cmd_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
hdl/wps_pkg.sv
hdl/wps_in_if.sv
hdl/wps_out_if.sv
hdl/wps_ram.sv
hdl/wps_ctrl.sv
hdl/wps_dpath.sv
hdl/waypoint_path_stepper.sv
hdl/wps_checker.sv
bench/testbench.sv
